### rtl/core/cbt_pkg.sv
// Shared types and constants for the cartridge bank and IRQ timer block.
// Used by cbt_exec and cartridge_bank_and_irq_timer; depends on nothing.
`default_nettype none

package cbt_pkg;

  // Work RAM size and the address bits it needs
  localparam int WRAM_BYTES = 8192;
  localparam int WRAM_AW    = $clog2(WRAM_BYTES);

  // Timer count: 16 bits plus a sign bit
  localparam int COUNT_W = 17;

  // Item modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Access targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_ROM  = 2'd1;
  localparam logic [1:0] TGT_WRAM = 2'd2;

  // Register map
  localparam logic [7:0]  PAGE_LATCH   = 8'h4A;
  localparam logic [7:0]  PAGE_BANK    = 8'h51;
  localparam logic [15:0] ADDR_TMR_LO  = 16'h4020;
  localparam logic [15:0] ADDR_TMR_HI  = 16'h4021;
  localparam logic [15:0] ADDR_MIRROR  = 16'h4025;
  localparam logic [15:0] ADDR_STATUS  = 16'h4030;
  localparam logic [15:0] WRAM_BASE    = 16'h6000;
  localparam logic [15:0] WRAM_LAST    = 16'h7FFF;
  localparam logic [15:0] ROM_BASE     = 16'h8000;
  localparam logic [15:0] ROM_FIX_BASE = 16'hC000;
  localparam logic [2:0]  FIXED_BANK   = 3'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } access_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               status_hit;
    logic [1:0]         target;
    logic [16:0]        rom_address;
    logic [WRAM_AW-1:0] wram_address;
    logic               irq_line;
    logic               mirroring;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/cbt_exec.sv
// Mapper state (bank latch, PRG bank, mirroring, IRQ timer) and the
// single-pass logic that turns one transaction into its result. Uses cbt_pkg.
`default_nettype none

module cbt_exec (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire cbt_pkg::access_t item,
  output cbt_pkg::result_t     result
);
  import cbt_pkg::*;

  logic [2:0]         bank_latch, bank_latch_next;
  logic [2:0]         prg_bank, prg_bank_next;
  logic               mirror_bit, mirror_bit_next;
  logic               timer_enable, timer_enable_next;
  logic [COUNT_W-1:0] timer_count, timer_count_next;
  logic               irq_pending, irq_pending_next;

  logic               in_wram;
  logic [COUNT_W-1:0] count_sub;
  logic [15:0]        wram_off;
  logic [2:0]         bank;

  // Next state and result for the current transaction
  always_comb begin
    bank_latch_next   = bank_latch;
    prg_bank_next     = prg_bank;
    mirror_bit_next   = mirror_bit;
    timer_enable_next = timer_enable;
    timer_count_next  = timer_count;
    irq_pending_next  = irq_pending;

    in_wram   = (item.address >= WRAM_BASE) && (item.address <= WRAM_LAST);
    wram_off  = item.address - WRAM_BASE;
    count_sub = timer_count - {{(COUNT_W-8){1'b0}}, item.cycles};
    bank      = (item.address >= ROM_FIX_BASE) ? FIXED_BANK : prg_bank;

    result.read_data    = '0;
    result.status_hit   = 1'b0;
    result.target       = TGT_NONE;
    result.rom_address  = '0;
    result.wram_address = '0;

    case (item.mode)
      MODE_WRITE: begin
        if (in_wram) begin
          result.target       = TGT_WRAM;
          result.wram_address = wram_off[WRAM_AW-1:0];
        end else if (item.address[15:8] == PAGE_LATCH) begin
          bank_latch_next = {item.address[6], item.address[3:2]};
        end else if (item.address[15:8] == PAGE_BANK) begin
          prg_bank_next = bank_latch;
        end else if (item.address == ADDR_TMR_LO) begin
          irq_pending_next = 1'b0;
          timer_count_next = {1'b0, timer_count[15:8], item.data};
        end else if (item.address == ADDR_TMR_HI) begin
          irq_pending_next  = 1'b0;
          timer_count_next  = {1'b0, item.data, timer_count[7:0]};
          timer_enable_next = 1'b1;
        end else if (item.address == ADDR_MIRROR) begin
          mirror_bit_next = ~item.data[3];
        end
      end
      MODE_READ: begin
        if (item.address == ADDR_STATUS) begin
          result.read_data  = {7'd0, irq_pending};
          result.status_hit = 1'b1;
          irq_pending_next  = 1'b0;
        end else if (in_wram) begin
          result.target       = TGT_WRAM;
          result.wram_address = wram_off[WRAM_AW-1:0];
        end else if (item.address >= ROM_BASE) begin
          result.target      = TGT_ROM;
          result.rom_address = {bank, item.address[13:0]};
        end
      end
      MODE_TICK: begin
        if (timer_enable) begin
          timer_count_next = count_sub;
          if ((count_sub == '0) || count_sub[COUNT_W-1]) begin
            timer_enable_next = 1'b0;
            irq_pending_next  = 1'b1;
          end
        end
      end
      default: begin
        // unused mode: no state change
      end
    endcase

    result.irq_line  = irq_pending_next;
    result.mirroring = mirror_bit_next;
  end

  // State registers, updated as each transaction moves to the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_latch   <= '0;
      prg_bank     <= '0;
      mirror_bit   <= 1'b0;
      timer_enable <= 1'b0;
      timer_count  <= '0;
      irq_pending  <= 1'b0;
    end else if (en) begin
      bank_latch   <= bank_latch_next;
      prg_bank     <= prg_bank_next;
      mirror_bit   <= mirror_bit_next;
      timer_enable <= timer_enable_next;
      timer_count  <= timer_count_next;
      irq_pending  <= irq_pending_next;
    end
  end

  // IRQ is raised only by a tick
  a_irq_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_pending) |-> $past(en && (item.mode == MODE_TICK)))
    else $error("IRQ raised without a tick");

  // A firing tick always disables the timer
  a_fire_disables: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_pending) |-> !timer_enable)
    else $error("timer still enabled after firing");

  // State only moves when a transaction advances
  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(timer_count) && $stable(prg_bank) && $stable(bank_latch))
    else $error("state changed without a transaction");

endmodule

`default_nettype wire

### rtl/core/cartridge_bank_and_irq_timer.sv
// Top level of the cartridge bank and IRQ timer block: input register,
// cbt_exec, and the result register. Uses cbt_pkg and cbt_exec.
`default_nettype none

// Each transaction (bus write, bus read or cycle tick) is captured in an input
// register, then passes the bank, mirroring and timer logic into a result
// register, from which the result is offered. A new transaction is accepted
// every cycle as long as the result side keeps taking results; a result held
// by result_stall backs up into the input register and then access_stall.
// State updates in strict transaction order, and irq_line and mirroring in
// each result reflect the state after that transaction.

module cartridge_bank_and_irq_timer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             access_valid,
  output logic                  access_stall,
  input  wire cbt_pkg::access_t access,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output cbt_pkg::result_t      result
);
  import cbt_pkg::*;

  logic    held_valid;
  access_t held;
  logic    advance;
  result_t exec_result;

  // Move the held transaction on when the result register is free
  assign advance      = held_valid && (!result_valid || !result_stall);
  assign access_stall = held_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!access_stall) begin
      held_valid <= access_valid;
    end
    if (!access_stall && access_valid) begin
      held <= access;
    end
  end

  cbt_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (held),
    .result (exec_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= exec_result;
    end
  end

  // A status read never maps to memory and always leaves the IRQ clear
  a_status_read: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status_hit |->
      (result.target == TGT_NONE) && !result.irq_line)
    else $error("status read with target or pending IRQ");

  // read_data is only driven on a status read
  a_read_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.status_hit |-> result.read_data == '0)
    else $error("read_data set outside a status read");

  // Address outputs are zero unless their target is selected
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      ((result.target == TGT_ROM) || (result.rom_address == '0)) &&
      ((result.target == TGT_WRAM) || (result.wram_address == '0)))
    else $error("address output set for the wrong target");

endmodule

`default_nettype wire
